FILE: rtl/dmwc_pkg.sv
package dmwc_pkg;

  localparam int unsigned NumLinesDefault = 1024;
  localparam int unsigned WordW           = 32;
  localparam int unsigned WordsPerLine    = 4;
  localparam int unsigned AddrW           = 32;
  localparam int unsigned OffsetW         = 4;
  localparam int unsigned BlkW            = AddrW - OffsetW;

  typedef logic [WordsPerLine-1:0][WordW-1:0] line_words_t;

  // Tag store entry: the full block number stands in for the tag, so the
  // write-back address needs no rebuild from tag and index.
  typedef struct packed {
    logic            valid;
    logic            dirty;
    logic [BlkW-1:0] blk;
  } meta_t;

  typedef enum logic [1:0] {
    CtrlIdle      = 2'd0,
    CtrlCompare   = 2'd1,
    CtrlWriteBack = 2'd2,
    CtrlAllocate  = 2'd3
  } ctrl_state_e;

  typedef enum logic [2:0] {
    PhClear,
    PhIdle,
    PhMul,
    PhSub,
    PhRead,
    PhExec
  } phase_e;

  typedef struct packed {
    logic             request_valid;
    logic             command;
    logic [AddrW-1:0] request_address;
    logic [WordW-1:0] store_word;
    logic             mem_ready;
    logic [WordW-1:0] fill_word0;
    logic [WordW-1:0] fill_word1;
    logic [WordW-1:0] fill_word2;
    logic [WordW-1:0] fill_word3;
  } req_t;

  typedef struct packed {
    logic             req_done;
    logic [WordW-1:0] read_data;
    logic             mem_request;
    logic             mem_write;
    logic [AddrW-1:0] mem_address;
    logic [WordW-1:0] victim_word0;
    logic [WordW-1:0] victim_word1;
    logic [WordW-1:0] victim_word2;
    logic [WordW-1:0] victim_word3;
    logic [1:0]       fsm_state;
  } rsp_t;

endpackage

FILE: rtl/dmwc_ram.sv
module dmwc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/dmwc_line_index.sv
module dmwc_line_index
  import dmwc_pkg::*;
#(
  parameter int unsigned NumLines = NumLinesDefault
) (
  input  logic                        clk_i,
  input  logic [BlkW-1:0]             blk_i,
  output logic [$clog2(NumLines)-1:0] idx_o
);

  localparam int unsigned IdxW    = $clog2(NumLines);
  localparam int unsigned Shift   = BlkW + IdxW;
  localparam int unsigned RecipW  = BlkW + 2;
  localparam int unsigned ProdW   = BlkW + RecipW;
  localparam logic [63:0] RecipFull = (64'd1 << Shift) / 64'(NumLines);
  localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];
  localparam logic [BlkW-1:0] NumLinesBlk = BlkW'(NumLines);
  localparam logic [IdxW:0] NumLinesRem = (IdxW+1)'(NumLines);

  logic [ProdW-1:0] prod;
  logic [BlkW-1:0]  quot_d, quot_q;
  logic [IdxW:0]    rem_d, rem_q;

  // Quotient from the reciprocal falls short by at most one, so the
  // remainder stays below twice the line count.
  assign prod   = {{RecipW{1'b0}}, blk_i} * {{BlkW{1'b0}}, Recip};
  assign quot_d = BlkW'(prod >> Shift);
  assign rem_d  = (IdxW+1)'(blk_i - BlkW'(quot_q * NumLinesBlk));

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign idx_o = (rem_q >= NumLinesRem) ? IdxW'(rem_q - NumLinesRem) : IdxW'(rem_q);

endmodule

FILE: rtl/direct_mapped_writeback_cache_fsm.sv
// A result beat follows each accepted input beat. A new beat is accepted only once
// the previous one has left execute, after the two registered steps of the line
// index reduction and the registered read of the tag and data memories.
// Reset clears the controller and output registers, then a clearing pass over all
// NUM_LINES entries zeroes every tag entry; in_ready_o stays low during the pass.
module direct_mapped_writeback_cache_fsm
  import dmwc_pkg::*;
#(
  parameter int unsigned NUM_LINES = NumLinesDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int unsigned IdxW    = $clog2(NUM_LINES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_LINES - 1);

  // Phase sequencer and controller state
  phase_e      phase_q, phase_d;
  ctrl_state_e ctrl_q, ctrl_d;
  logic [IdxW-1:0] clr_cnt_q, clr_cnt_d;
  logic        out_valid_q, out_valid_d;

  // Request held for the whole beat
  req_t req_q;

  // Architectural output registers
  logic              ready_q, ready_d;
  logic [WordW-1:0]  read_word_q, read_word_d;
  logic              mem_req_q, mem_req_d;
  logic              mem_write_q, mem_write_d;
  logic [AddrW-1:0]  mem_addr_q, mem_addr_d;
  line_words_t       victim_q, victim_d;

  // Memory ports
  logic [IdxW-1:0] line_idx;
  logic            mem_re;
  logic            meta_we;
  logic [IdxW-1:0] meta_waddr;
  meta_t           meta_wdata, meta_rd;
  logic            data_we;
  line_words_t     data_wdata, data_rd;

  logic [BlkW-1:0] blk;
  logic [1:0]      word_sel;
  logic            ex_fire;
  logic            hit;
  line_words_t     fill_words;

  assign blk      = req_q.request_address[AddrW-1:OffsetW];
  assign word_sel = req_q.request_address[3:2];
  assign fill_words = {req_q.fill_word3, req_q.fill_word2,
                       req_q.fill_word1, req_q.fill_word0};

  assign in_ready_o = (phase_q == PhIdle);
  assign ex_fire    = (phase_q == PhExec) && (!out_valid_q || out_ready_i);
  assign mem_re     = (phase_q == PhRead);
  assign hit        = meta_rd.valid && (meta_rd.blk == blk);
  assign meta_waddr = (phase_q == PhClear) ? clr_cnt_q : line_idx;

  // Line index = block number modulo the line count
  dmwc_line_index #(
    .NumLines (NUM_LINES)
  ) u_line_index (
    .clk_i (clk_i),
    .blk_i (blk),
    .idx_o (line_idx)
  );

  // Tag store: valid, dirty and block number per line
  dmwc_ram #(
    .Width ($bits(meta_t)),
    .Depth (NUM_LINES)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (mem_re),
    .raddr_i (line_idx),
    .rdata_o (meta_rd)
  );

  // Data store: four words per line
  dmwc_ram #(
    .Width ($bits(line_words_t)),
    .Depth (NUM_LINES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (line_idx),
    .wdata_i (data_wdata),
    .re_i    (mem_re),
    .raddr_i (line_idx),
    .rdata_o (data_rd)
  );

  // Phase sequencer: clear pass, then accept, reduce index, read, execute
  always_comb begin
    phase_d   = phase_q;
    clr_cnt_d = clr_cnt_q;
    unique case (phase_q)
      PhClear: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LastIdx) begin
          phase_d = PhIdle;
        end
      end
      PhIdle: begin
        if (in_valid_i) begin
          phase_d = PhMul;
        end
      end
      PhMul:  phase_d = PhSub;
      PhSub:  phase_d = PhRead;
      PhRead: phase_d = PhExec;
      PhExec: begin
        // Hold here while the previous result beat is still unclaimed
        if (ex_fire) begin
          phase_d = PhIdle;
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  // Controller step: compare, write-back and allocate for the addressed line
  always_comb begin
    ctrl_d      = ctrl_q;
    ready_d     = ready_q;
    read_word_d = read_word_q;
    mem_req_d   = mem_req_q;
    mem_write_d = mem_write_q;
    mem_addr_d  = mem_addr_q;
    victim_d    = victim_q;
    meta_we     = 1'b0;
    meta_wdata  = '0;
    data_we     = 1'b0;
    data_wdata  = data_rd;

    if (phase_q == PhClear) begin
      meta_we = 1'b1;
    end

    if (ex_fire) begin
      unique case (ctrl_q)
        CtrlIdle: begin
          ready_d = 1'b0;
          if (req_q.request_valid) begin
            ctrl_d = CtrlCompare;
          end
        end
        CtrlCompare: begin
          if (hit) begin
            ready_d = 1'b1;
            ctrl_d  = CtrlIdle;
            if (req_q.command) begin
              data_we              = 1'b1;
              data_wdata[word_sel] = req_q.store_word;
              meta_we              = 1'b1;
              meta_wdata           = meta_rd;
              meta_wdata.dirty     = 1'b1;
            end else begin
              read_word_d = data_rd[word_sel];
            end
          end else begin
            ready_d   = 1'b0;
            mem_req_d = 1'b1;
            if (meta_rd.valid && meta_rd.dirty) begin
              // Dirty victim: write it back before the fetch
              ctrl_d      = CtrlWriteBack;
              mem_write_d = 1'b1;
              mem_addr_d  = {meta_rd.blk, {OffsetW{1'b0}}};
              victim_d    = data_rd;
            end else begin
              ctrl_d      = CtrlAllocate;
              mem_write_d = 1'b0;
              mem_addr_d  = {blk, {OffsetW{1'b0}}};
            end
          end
        end
        CtrlWriteBack: begin
          if (req_q.mem_ready) begin
            ctrl_d      = CtrlAllocate;
            mem_req_d   = 1'b1;
            mem_write_d = 1'b0;
            mem_addr_d  = {blk, {OffsetW{1'b0}}};
          end
        end
        CtrlAllocate: begin
          if (req_q.mem_ready) begin
            // Install the fetched block clean, then compare again
            data_we          = 1'b1;
            data_wdata       = fill_words;
            meta_we          = 1'b1;
            meta_wdata.valid = 1'b1;
            meta_wdata.dirty = 1'b0;
            meta_wdata.blk   = blk;
            mem_req_d        = 1'b0;
            ctrl_d           = CtrlCompare;
          end
        end
        default: ctrl_d = CtrlIdle;
      endcase
    end
  end

  assign out_valid_d = ex_fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhClear;
      ctrl_q      <= CtrlIdle;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      ready_q     <= 1'b0;
      read_word_q <= '0;
      mem_req_q   <= 1'b0;
      mem_write_q <= 1'b0;
      mem_addr_q  <= '0;
      victim_q    <= '0;
    end else begin
      phase_q     <= phase_d;
      ctrl_q      <= ctrl_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      ready_q     <= ready_d;
      read_word_q <= read_word_d;
      mem_req_q   <= mem_req_d;
      mem_write_q <= mem_write_d;
      mem_addr_q  <= mem_addr_d;
      victim_q    <= victim_d;
    end
  end

  // Capture the request beat; hold it until the step completes
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.req_done     = ready_q;
  assign out_data_o.read_data    = read_word_q;
  assign out_data_o.mem_request  = mem_req_q;
  assign out_data_o.mem_write    = mem_write_q;
  assign out_data_o.mem_address  = mem_addr_q;
  assign out_data_o.victim_word0 = victim_q[0];
  assign out_data_o.victim_word1 = victim_q[1];
  assign out_data_o.victim_word2 = victim_q[2];
  assign out_data_o.victim_word3 = victim_q[3];
  assign out_data_o.fsm_state    = ctrl_q;

endmodule

FILE: tb/direct_mapped_writeback_cache_fsm_tb.sv
`timescale 1ns / 1ps

module direct_mapped_writeback_cache_fsm_tb;
  import dmwc_pkg::*;

  // Request command encoding carried in req_t.command
  localparam bit CmdRead  = 1'b0;
  localparam bit CmdWrite = 1'b1;

  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned BeatsPerPhase = 225;

  // Tracks the controller one tick per request beat and queues the expected response beats.
  class cache_scoreboard;
    ctrl_state_e ctrl_state;
    bit          line_valid [NumLinesDefault];
    bit          line_dirty [NumLinesDefault];
    bit [31:0]   line_tag   [NumLinesDefault];
    line_words_t line_data  [NumLinesDefault];
    bit          ready_q;
    bit [31:0]   read_word_q;
    bit          mem_req_q;
    bit          mem_wr_q;
    bit [31:0]   mem_addr_q;
    line_words_t victim_q;
    rsp_t        expected_rsp_q[$];
    int unsigned errors, checked, noted, hits, writebacks, fills;

    function new();
      ctrl_state  = CtrlIdle;
      ready_q     = 1'b0;
      read_word_q = '0;
      mem_req_q   = 1'b0;
      mem_wr_q    = 1'b0;
      mem_addr_q  = '0;
      victim_q    = '0;
      foreach (line_valid[i]) begin
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_tag[i]   = '0;
        line_data[i]  = '0;
      end
    endfunction

    function rsp_t predict_tick(req_t r);
      bit [1:0]    wsel;
      bit [27:0]   blk;
      int unsigned idx;
      bit [31:0]   tag;
      rsp_t        o;
      wsel = r.request_address[3:2];
      blk  = r.request_address[31:4];
      idx  = blk % NumLinesDefault;
      tag  = blk / NumLinesDefault;
      case (ctrl_state)
        CtrlIdle: begin
          ready_q = 1'b0;
          if (r.request_valid) ctrl_state = CtrlCompare;
        end
        CtrlCompare: begin
          if (line_valid[idx] && line_tag[idx] == tag) begin
            ready_q = 1'b1;
            hits++;
            if (r.command == CmdWrite) begin
              line_data[idx][wsel] = r.store_word;
              line_dirty[idx] = 1'b1;
            end else begin
              read_word_q = line_data[idx][wsel];
            end
            ctrl_state = CtrlIdle;
          end else begin
            ready_q   = 1'b0;
            mem_req_q = 1'b1;
            if (line_valid[idx] && line_dirty[idx]) begin
              // Dirty victim: push the old block out before the fill
              ctrl_state = CtrlWriteBack;
              mem_wr_q   = 1'b1;
              mem_addr_q = 32'((line_tag[idx] * NumLinesDefault + idx) << 4);
              victim_q   = line_data[idx];
              writebacks++;
            end else begin
              ctrl_state = CtrlAllocate;
              mem_wr_q   = 1'b0;
              mem_addr_q = {r.request_address[31:4], 4'h0};
            end
          end
        end
        CtrlWriteBack: begin
          if (r.mem_ready) begin
            ctrl_state = CtrlAllocate;
            mem_req_q  = 1'b1;
            mem_wr_q   = 1'b0;
            mem_addr_q = {r.request_address[31:4], 4'h0};
          end
        end
        default: begin
          if (r.mem_ready) begin
            line_data[idx]  = {r.fill_word3, r.fill_word2, r.fill_word1, r.fill_word0};
            line_valid[idx] = 1'b1;
            line_dirty[idx] = 1'b0;
            line_tag[idx]   = tag;
            mem_req_q       = 1'b0;
            ctrl_state      = CtrlCompare;
            fills++;
          end
        end
      endcase
      o.req_done     = ready_q;
      o.read_data    = read_word_q;
      o.mem_request  = mem_req_q;
      o.mem_write    = mem_wr_q;
      o.mem_address  = mem_addr_q;
      o.victim_word0 = victim_q[0];
      o.victim_word1 = victim_q[1];
      o.victim_word2 = victim_q[2];
      o.victim_word3 = victim_q[3];
      o.fsm_state    = ctrl_state;
      return o;
    endfunction

    function void note_request(req_t r);
      expected_rsp_q.push_back(predict_tick(r));
      noted++;
    endfunction

    function void cmp_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %08h, actual %08h", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_response(rsp_t act);
      rsp_t exp_r;
      if (expected_rsp_q.size() == 0) begin
        $error("response beat arrived with nothing pending");
        errors++;
        return;
      end
      exp_r = expected_rsp_q.pop_front();
      checked++;
      cmp_field("req_done", exp_r.req_done, act.req_done);
      cmp_field("read_data", exp_r.read_data, act.read_data);
      cmp_field("mem_request", exp_r.mem_request, act.mem_request);
      cmp_field("mem_write", exp_r.mem_write, act.mem_write);
      cmp_field("mem_address", exp_r.mem_address, act.mem_address);
      cmp_field("victim_word0", exp_r.victim_word0, act.victim_word0);
      cmp_field("victim_word1", exp_r.victim_word1, act.victim_word1);
      cmp_field("victim_word2", exp_r.victim_word2, act.victim_word2);
      cmp_field("victim_word3", exp_r.victim_word3, act.victim_word3);
      cmp_field("fsm_state", exp_r.fsm_state, act.fsm_state);
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  req_t in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  cache_scoreboard sb;

  // Idle and stall odds in percent, changed per phase
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  bit          hold_off_req   = 1'b0;

  // Request the CPU is currently holding
  bit          cur_cmd   = CmdRead;
  logic [31:0] cur_addr  = '0;
  logic [31:0] cur_wdata = '0;

  direct_mapped_writeback_cache_fsm dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hard stop; a correct run ends well before this even with the clearing pass after reset.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Response sink: random back-pressure, plus one long hold-off on request so the block
  // fills up and stalls its input while the sender keeps offering beats.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // Check every response beat taken at a clock edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_response(out_data_o);
  end

  // Offer one request beat; hold valid and payload until it is taken.
  task automatic send_beat(input req_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
  endtask

  // Directed tick; the fill words differ per position so a wrong word select shows up.
  task automatic tick(input bit rv, input bit cmd, input logic [31:0] addr,
                      input logic [31:0] wdata, input bit mrdy, input logic [31:0] fill);
    req_t r;
    r.request_valid   = rv;
    r.command         = cmd;
    r.request_address = addr;
    r.store_word      = wdata;
    r.mem_ready       = mrdy;
    r.fill_word0      = fill;
    r.fill_word1      = fill ^ 32'h1111_1111;
    r.fill_word2      = fill ^ 32'h2222_2222;
    r.fill_word3      = fill ^ 32'h3333_3333;
    send_beat(r);
  endtask

  // Mostly a small pool of tags and lines so hits, clean misses and dirty evictions all occur.
  function automatic logic [31:0] pick_addr();
    logic [17:0] t;
    logic [9:0]  i;
    if ($urandom_range(0, 9) == 0) return $urandom();
    case ($urandom_range(0, 2))
      0: t = '0;
      1: t = '1;
      default: t = 18'h15555;
    endcase
    case ($urandom_range(0, 3))
      0: i = '0;
      1: i = 10'd1;
      2: i = 10'h2AA;
      default: i = '1;
    endcase
    return {t, i, 4'($urandom())};
  endfunction

  // Build the next tick from the predicted controller state: well-formed held requests
  // with a little noise (dropped valid, address, data or command changed mid-miss).
  function automatic req_t next_tick();
    req_t r;
    r.fill_word0 = $urandom();
    r.fill_word1 = $urandom();
    r.fill_word2 = $urandom();
    r.fill_word3 = $urandom();
    r.mem_ready  = 1'($urandom_range(0, 1));
    if (sb.ctrl_state == CtrlIdle) begin
      cur_cmd   = 1'($urandom_range(0, 1));
      cur_wdata = $urandom();
      if ($urandom_range(0, 99) < 85) begin
        cur_addr        = pick_addr();
        r.request_valid = 1'b1;
      end else begin
        cur_addr        = $urandom();
        r.request_valid = 1'b0;
      end
    end else begin
      r.request_valid = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 99) < 4) cur_addr = pick_addr();
      if ($urandom_range(0, 99) < 4) cur_wdata = $urandom();
      if ($urandom_range(0, 99) < 2) cur_cmd = ~cur_cmd;
      if (sb.ctrl_state != CtrlCompare) r.mem_ready = ($urandom_range(0, 99) < 60);
    end
    r.command         = cur_cmd;
    r.request_address = cur_addr;
    r.store_word      = cur_wdata;
    return r;
  endfunction

  initial begin
    int unsigned src_pct  [4];
    int unsigned sink_pct [4];
    src_pct  = '{0, 73, 0, 37};
    sink_pct = '{0, 0, 73, 37};
    sb = new();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: memory ready ignored in idle
    tick(1'b0, CmdWrite, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    // Cold read miss at address zero; ready ignored in compare, one wait in allocate
    tick(1'b1, CmdRead, 32'h0, 32'h0, 1'b1, 32'h0);
    tick(1'b1, CmdRead, 32'h0, 32'h0, 1'b1, 32'h0);
    tick(1'b1, CmdRead, 32'h0, 32'h0, 1'b0, 32'h0);
    tick(1'b1, CmdRead, 32'h0, 32'h0, 1'b1, 32'h0);
    // Drop the request after idle; compare still completes as a read hit
    tick(1'b0, CmdRead, 32'h0, 32'h0, 1'b0, 32'h0);
    // Write hit to the last word, marking the line dirty
    tick(1'b1, CmdWrite, 32'h0000_000C, 32'hFFFF_FFFF, 1'b0, 32'h0);
    tick(1'b1, CmdWrite, 32'h0000_000C, 32'hFFFF_FFFF, 1'b0, 32'h0);
    // Same line, top tag: dirty eviction, write-back wait, then fill
    tick(1'b1, CmdRead, 32'hFFFF_C00C, 32'h0, 1'b0, 32'h0);
    tick(1'b1, CmdRead, 32'hFFFF_C00C, 32'h0, 1'b0, 32'h0);
    tick(1'b1, CmdRead, 32'hFFFF_C00C, 32'h0, 1'b0, 32'h0);
    tick(1'b1, CmdRead, 32'hFFFF_C00C, 32'h0, 1'b1, 32'h0);
    tick(1'b1, CmdRead, 32'hFFFF_C00C, 32'h0, 1'b1, 32'hFFFF_FFFF);
    tick(1'b1, CmdRead, 32'hFFFF_C00C, 32'h0, 1'b1, 32'h0);
    // Address changed mid-miss: fill lands at the new address's tag
    tick(1'b1, CmdWrite, 32'hFFFF_FFFC, 32'h1234_5678, 1'b0, 32'h0);
    tick(1'b1, CmdWrite, 32'hFFFF_FFFC, 32'h1234_5678, 1'b0, 32'h0);
    tick(1'b1, CmdWrite, 32'h0000_3FF4, 32'h1234_5678, 1'b1, 32'h0F0F_0F0F);
    tick(1'b1, CmdWrite, 32'h0000_3FF4, 32'h0, 1'b0, 32'h0);
    tick(1'b0, CmdRead, 32'h0, 32'h0, 1'b1, 32'h0);

    // Random phases with different idle and stall mixes; long hold-off in the first
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = src_pct[p];
      sink_stall_pct = sink_pct[p];
      if (p == 0) hold_off_req = 1'b1;
      repeat (BeatsPerPhase) send_beat(next_tick());
    end
    in_valid_i <= 1'b0;

    // Drain, then give the pipeline time to show any stray beat
    while (sb.expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d controller ticks, checked %0d response beats", sb.noted, sb.checked);
    $display("  with %0d hits, %0d dirty write-backs and %0d block fills",
             sb.hits, sb.writebacks, sb.fills);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: direct_mapped_writeback_cache_fsm.f
rtl/dmwc_pkg.sv
rtl/dmwc_ram.sv
rtl/dmwc_line_index.sv
rtl/direct_mapped_writeback_cache_fsm.sv
tb/direct_mapped_writeback_cache_fsm_tb.sv
